@@ rtl/aet_pkg.sv @@
package aet_pkg;

    localparam int VTX_W    = 6;
    localparam int WEIGHT_W = 32;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic STATUS_DONE   = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    localparam logic signed [WEIGHT_W-1:0] WEIGHT_INF = 32'sh7FFF_FFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEG_S,
        ST_DEG_D,
        ST_CHECK,
        ST_WR_S,
        ST_WR_D,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic deg_rd;
        logic deg_sel_dst;
        logic cap_src;
        logic cap_dst;
        logic wr_src;
        logic wr_dst;
        logic scan;
    } t_dp_cmd;

    typedef struct packed {
        logic is_lookup;
        logic mirror;
        logic ok;
        logic hit;
        logic scan_end;
    } t_dp_stat;

endpackage

@@ rtl/aet_ram.sv @@
module aet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/aet_ctrl.sv @@
module aet_ctrl
    import aet_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    output logic     o_strobe,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        busy     = 1'b1;
        o_strobe = 1'b0;
        case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DEG_S;
                end
            end
            ST_DEG_S: begin
                o_cmd.deg_rd = 1'b1;
                n_state      = ST_DEG_D;
            end
            ST_DEG_D: begin
                o_cmd.cap_src     = 1'b1;
                o_cmd.deg_rd      = 1'b1;
                o_cmd.deg_sel_dst = 1'b1;
                n_state           = i_stat.is_lookup ? ST_SCAN : ST_CHECK;
            end
            ST_CHECK: begin
                o_cmd.cap_dst = 1'b1;
                n_state       = i_stat.ok ? ST_WR_S : ST_DONE;
            end
            ST_WR_S: begin
                o_cmd.wr_src = 1'b1;
                n_state      = i_stat.mirror ? ST_WR_D : ST_DONE;
            end
            ST_WR_D: begin
                o_cmd.wr_dst = 1'b1;
                n_state      = ST_DONE;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.hit || i_stat.scan_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_strobe = 1'b1;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/aet_dpath.sv @@
module aet_dpath
    import aet_pkg::*;
#(
    parameter int VERTEX_COUNT = 64,
    parameter int MAX_DEGREE   = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    output t_dp_stat                   o_stat,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_wdata,
    input  logic                       i_command,
    input  logic [VTX_W-1:0]           i_source_vertex,
    input  logic [VTX_W-1:0]           i_dest_vertex,
    input  logic signed [WEIGHT_W-1:0] i_edge_weight,
    output logic                       o_status,
    output logic                       o_found,
    output logic signed [WEIGHT_W-1:0] o_found_weight
);

    localparam int VTX_STORE  = (VERTEX_COUNT < (1 << VTX_W)) ? VERTEX_COUNT : (1 << VTX_W);
    localparam int VW         = $clog2(VTX_STORE);
    localparam int DW         = $clog2(MAX_DEGREE + 1);
    localparam int SLOT_DEPTH = VTX_STORE * MAX_DEGREE;
    localparam int AW         = $clog2(SLOT_DEPTH);
    localparam int SW         = VTX_W + WEIGHT_W;

    logic                       r_dir;
    logic [VTX_STORE-1:0]       r_deg_vld;
    logic                       r_deg_rvld;
    logic                       r_cmd;
    logic [VTX_W-1:0]           r_src;
    logic [VTX_W-1:0]           r_dst;
    logic signed [WEIGHT_W-1:0] r_w;
    logic [AW-1:0]              r_sbase;
    logic [AW-1:0]              r_dbase;
    logic [DW-1:0]              r_deg_s;
    logic [DW-1:0]              r_deg_d;
    logic                       r_ok;
    logic                       r_hit;
    logic signed [WEIGHT_W-1:0] r_wt;
    logic [DW-1:0]              r_rk;
    logic                       r_pend;

    logic [VW-1:0]    src_idx;
    logic [VW-1:0]    dst_idx;
    logic [VW-1:0]    deg_raddr;
    logic [DW-1:0]    deg_rdata;
    logic [DW-1:0]    deg_live;
    logic             deg_we;
    logic [VW-1:0]    deg_waddr;
    logic [DW-1:0]    deg_wdata;
    logic [DW-1:0]    deg_d2;
    logic             slot_we;
    logic [AW-1:0]    slot_waddr;
    logic [SW-1:0]    slot_wdata;
    logic             slot_re;
    logic [AW-1:0]    slot_raddr;
    logic [SW-1:0]    slot_rdata;
    logic             mirror;
    logic             src_ok;
    logic             dst_ok;
    logic             fit;
    logic             ok_live;
    logic             hit;
    logic [VW-1:0]    in_src_idx;
    logic [VW-1:0]    in_dst_idx;

    assign in_src_idx = i_source_vertex[VW-1:0];
    assign in_dst_idx = i_dest_vertex[VW-1:0];
    assign src_idx    = r_src[VW-1:0];
    assign dst_idx    = r_dst[VW-1:0];

    // degree read with unwritten entries reading as zero
    assign deg_raddr = i_cmd.deg_sel_dst ? dst_idx : src_idx;
    assign deg_live  = r_deg_rvld ? deg_rdata : '0;

    assign mirror = !r_dir;
    assign src_ok = int'(r_src) < VTX_STORE;
    assign dst_ok = !mirror || (int'(r_dst) < VTX_STORE);

    always_comb begin
        if (mirror && (r_src == r_dst)) begin
            fit = ({1'b0, r_deg_s} + (DW+1)'(2)) <= (DW+1)'(MAX_DEGREE);
        end else begin
            fit = ({1'b0, r_deg_s} < (DW+1)'(MAX_DEGREE))
               && (!mirror || ({1'b0, deg_live} < (DW+1)'(MAX_DEGREE)));
        end
    end

    assign ok_live = src_ok && dst_ok && fit;

    // second entry of a self-loop lands after the first one
    assign deg_d2 = (r_src == r_dst) ? (r_deg_s + DW'(1)) : r_deg_d;

    always_comb begin
        deg_we     = i_cmd.wr_src || i_cmd.wr_dst;
        deg_waddr  = i_cmd.wr_dst ? dst_idx : src_idx;
        deg_wdata  = i_cmd.wr_dst ? (deg_d2 + DW'(1)) : (r_deg_s + DW'(1));
        slot_we    = deg_we;
        slot_waddr = i_cmd.wr_dst ? (r_dbase + AW'(deg_d2)) : (r_sbase + AW'(r_deg_s));
        slot_wdata = i_cmd.wr_dst ? {r_src, r_w} : {r_dst, r_w};
    end

    assign slot_re    = i_cmd.scan && (r_rk < r_deg_s);
    assign slot_raddr = r_sbase + AW'(r_rk);
    assign hit        = r_pend && (slot_rdata[SW-1 -: VTX_W] == r_dst);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir     <= 1'b0;
            r_deg_vld <= '0;
        end else begin
            if (i_cfg_we) begin
                r_dir <= i_cfg_wdata;
            end
            if (deg_we) begin
                r_deg_vld[deg_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_command;
            r_src   <= i_source_vertex;
            r_dst   <= i_dest_vertex;
            r_w     <= i_edge_weight;
            r_sbase <= AW'(int'(in_src_idx) * MAX_DEGREE);
            r_dbase <= AW'(int'(in_dst_idx) * MAX_DEGREE);
            r_ok    <= 1'b0;
            r_hit   <= 1'b0;
            r_rk    <= '0;
            r_pend  <= 1'b0;
        end else if (i_cmd.scan) begin
            if (slot_re) begin
                r_rk <= r_rk + DW'(1);
            end
            r_pend <= slot_re;
            if (hit) begin
                r_hit <= 1'b1;
                r_wt  <= slot_rdata[WEIGHT_W-1:0];
            end
        end
        if (i_cmd.deg_rd) begin
            r_deg_rvld <= r_deg_vld[deg_raddr];
        end
        if (i_cmd.cap_src) begin
            r_deg_s <= src_ok ? deg_live : '0;
        end
        if (i_cmd.cap_dst) begin
            r_deg_d <= deg_live;
            r_ok    <= ok_live;
        end
    end

    aet_ram #(
        .WIDTH (DW),
        .DEPTH (VTX_STORE)
    ) u_deg_ram (
        .i_clk   (i_clk),
        .i_we    (deg_we),
        .i_waddr (deg_waddr),
        .i_wdata (deg_wdata),
        .i_re    (i_cmd.deg_rd),
        .i_raddr (deg_raddr),
        .o_rdata (deg_rdata)
    );

    aet_ram #(
        .WIDTH (SW),
        .DEPTH (SLOT_DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_re    (slot_re),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    assign o_stat.is_lookup = (r_cmd == CMD_LOOKUP);
    assign o_stat.mirror    = mirror;
    assign o_stat.ok        = ok_live;
    assign o_stat.hit       = hit;
    assign o_stat.scan_end  = !r_pend && !(r_rk < r_deg_s);

    assign o_status       = ((r_cmd == CMD_INSERT) && !r_ok) ? STATUS_REJECT : STATUS_DONE;
    assign o_found        = r_hit;
    assign o_found_weight = (r_cmd == CMD_INSERT) ? '0 : (r_hit ? r_wt : WEIGHT_INF);

endmodule

@@ rtl/adjacency_edge_table_core.sv @@
// insert: degree reads, check, source write, dest write if mirrored, then result strobe;
//   a rejected insert skips the writes. lookup: degree reads, then the list scan, one stored
//   entry compared per cycle from the slot ram; a match ends the scan early
// one item at a time; busy drops in the cycle after the strobe
// reset (synchronous, active low) clears directed_mode, the state machine and the valid bits of all degree counts
module adjacency_edge_table_core
    import aet_pkg::*;
#(
    parameter int VERTEX_COUNT = 64,
    parameter int MAX_DEGREE   = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_wdata,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_command,
    input  logic [VTX_W-1:0]           i_source_vertex,
    input  logic [VTX_W-1:0]           i_dest_vertex,
    input  logic signed [WEIGHT_W-1:0] i_edge_weight,
    output logic                       o_strobe,
    output logic                       o_status,
    output logic                       o_found,
    output logic signed [WEIGHT_W-1:0] o_found_weight
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    aet_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_cmd    (dp_cmd),
        .i_stat   (dp_stat)
    );

    aet_dpath #(
        .VERTEX_COUNT (VERTEX_COUNT),
        .MAX_DEGREE   (MAX_DEGREE)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_command       (i_command),
        .i_source_vertex (i_source_vertex),
        .i_dest_vertex   (i_dest_vertex),
        .i_edge_weight   (i_edge_weight),
        .o_status        (o_status),
        .o_found         (o_found),
        .o_found_weight  (o_found_weight)
    );

`ifndef NO_ASSERTIONS
    a_accept_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_strobe_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe while idle");

    a_strobe_single : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe && !busy)
        else $error("result strobe longer than one cycle");

    a_reject_nofound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == STATUS_REJECT)) |-> (!o_found && (o_found_weight == '0)))
        else $error("rejected insert reports a found edge");
`endif

endmodule
